/* rtl/core/mmd_pkg.sv */
// Package for the MIDI message decoder: field widths, message codes and the
// result record held in the output register. No dependencies.
`default_nettype none

package mmd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 2;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned PitchW = 15;

  // Message codes as they appear on the message field of a result.
  localparam logic [ByteW-1:0] MsgNoteOff         = 8'h08;
  localparam logic [ByteW-1:0] MsgNoteOn          = 8'h09;
  localparam logic [ByteW-1:0] MsgPolyAftertouch  = 8'h0A;
  localparam logic [ByteW-1:0] MsgControlChange   = 8'h0B;
  localparam logic [ByteW-1:0] MsgProgramChange   = 8'h0C;
  localparam logic [ByteW-1:0] MsgChannelPressure = 8'h0D;
  localparam logic [ByteW-1:0] MsgPitchBend       = 8'h0E;

  // High nibble of every system status byte.
  localparam logic [3:0] SysNibble = 4'hF;

  typedef struct packed {
    logic [ChanW-1:0]  channel;
    logic [ByteW-1:0]  message;
    logic [PitchW-1:0] pitch;
    logic [ByteW-1:0]  velocity;
    logic [ByteW-1:0]  pressure;
    logic [ByteW-1:0]  controller_number;
    logic [ByteW-1:0]  controller_value;
    logic [ByteW-1:0]  instrument;
  } mmd_result_t;

endpackage

`default_nettype wire

/* rtl/core/mmd_in_if.sv */
// Packet channel of the MIDI message decoder: valid/ready and the packet bytes.
// Depends on mmd_pkg for the field widths.
`default_nettype none

interface mmd_in_if;
  logic                        valid;
  logic                        ready;
  logic [mmd_pkg::ByteW-1:0]   first_byte;
  logic [mmd_pkg::ByteW-1:0]   second_byte;
  logic [mmd_pkg::ByteW-1:0]   third_byte;
  logic [mmd_pkg::LenW-1:0]    packet_length;

  modport source (output valid, first_byte, second_byte, third_byte, packet_length,
                  input ready);
  modport sink (input valid, first_byte, second_byte, third_byte, packet_length,
                output ready);
  modport monitor (input valid, ready, first_byte, second_byte, third_byte,
                   packet_length);
endinterface

`default_nettype wire

/* rtl/core/mmd_out_if.sv */
// Event channel of the MIDI message decoder: valid/ready and the decoded fields.
// Depends on mmd_pkg for the field widths.
`default_nettype none

interface mmd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mmd_pkg::ChanW-1:0]   channel;
  logic [mmd_pkg::ByteW-1:0]   message;
  logic [mmd_pkg::PitchW-1:0]  pitch;
  logic [mmd_pkg::ByteW-1:0]   velocity;
  logic [mmd_pkg::ByteW-1:0]   pressure;
  logic [mmd_pkg::ByteW-1:0]   controller_number;
  logic [mmd_pkg::ByteW-1:0]   controller_value;
  logic [mmd_pkg::ByteW-1:0]   instrument;

  modport source (output valid, channel, message, pitch, velocity, pressure,
                  controller_number, controller_value, instrument,
                  input ready);
  modport sink (input valid, channel, message, pitch, velocity, pressure,
                controller_number, controller_value, instrument,
                output ready);
  modport monitor (input valid, ready, channel, message, pitch, velocity, pressure,
                   controller_number, controller_value, instrument);
endinterface

`default_nettype wire

/* rtl/core/midi_message_decoder_unit.sv */
// MIDI message decoder top level: running-status register, decode logic and
// output register. Depends on mmd_pkg, mmd_in_if and mmd_out_if.
//
// Usage:
//   in_i carries one MIDI packet per beat: up to three bytes and the number
//   of valid bytes. out_o carries one decoded event per packet beat, in
//   packet order. A beat moves at a rising clk_i edge with valid and ready
//   both high.
//   The decode is a single combinational pass from the accepted packet and
//   the stored running status into the output register, so an event appears
//   on out_o in the cycle after its packet is taken. With the receiver ready,
//   one packet is taken in every cycle; the single output register sets that
//   figure.
//   A status byte in a packet updates the running status at the edge that
//   takes the packet, so the next packet, even in the following cycle,
//   already sees it.
//   When the receiver stalls, the event holds on out_o and in_i.ready stays
//   high only while the output register is empty; a packet is taken in the
//   same cycle as the held event leaves.
//   rst_ni (asynchronous, active low) empties the output register and clears
//   the running status to zero.
`default_nettype none

module midi_message_decoder_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mmd_in_if.sink     in_i,
  mmd_out_if.source  out_o
);
  import mmd_pkg::*;

  logic              in_fire;
  logic              out_valid_q;
  mmd_result_t       res_q;
  mmd_result_t       res_d;
  logic [ByteW-1:0]  rs_q;
  logic [ByteW-1:0]  rs_d;

  logic              is_data;
  logic              is_sys;
  logic              has_any;
  logic              have_one;
  logic              have_two;
  logic [ByteW-1:0]  par0;
  logic [ByteW-1:0]  par1;
  logic [ByteW-1:0]  msg;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    has_any = (in_i.packet_length != '0);
    is_sys  = (in_i.first_byte[7:4] == SysNibble);
    is_data = !in_i.first_byte[7];

    // A data byte in front means running status: parameters start one byte early.
    par0     = is_data ? in_i.first_byte  : in_i.second_byte;
    par1     = is_data ? in_i.second_byte : in_i.third_byte;
    have_one = is_data ? (in_i.packet_length >= 2'd1) : (in_i.packet_length >= 2'd2);
    have_two = is_data ? (in_i.packet_length >= 2'd2) : (in_i.packet_length == 2'd3);

    rs_d = rs_q;
    if (in_fire && has_any && !is_data) begin
      rs_d = in_i.first_byte;
    end

    res_d = '0;
    msg   = '0;
    if (has_any) begin
      if (is_sys) begin
        msg = in_i.first_byte;
      end else if (is_data) begin
        res_d.channel = rs_q[3:0];
        msg           = {4'h0, rs_q[7:4]};
      end else begin
        res_d.channel = in_i.first_byte[3:0];
        msg           = {4'h0, in_i.first_byte[7:4]};
      end
    end

    unique case (msg)
      MsgPolyAftertouch: begin
        if (have_two) begin
          res_d.pitch    = {7'd0, par0};
          res_d.pressure = par1;
        end
      end
      MsgControlChange: begin
        if (have_two) begin
          res_d.controller_number = par0;
          res_d.controller_value  = par1;
        end
      end
      MsgNoteOn, MsgNoteOff: begin
        if (have_two) begin
          res_d.pitch    = {7'd0, par0};
          res_d.velocity = par1;
          if (msg == MsgNoteOn && par1 == '0) begin
            msg = MsgNoteOff;
          end
        end
      end
      MsgPitchBend: begin
        if (have_two) begin
          res_d.pitch = {par1, 7'd0} | {7'd0, par0};
        end
      end
      MsgProgramChange: begin
        if (have_one) begin
          res_d.instrument = par0;
        end
      end
      MsgChannelPressure: begin
        if (have_one) begin
          res_d.pressure = par0;
        end
      end
      default: begin
      end
    endcase
    res_d.message = msg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rs_q        <= '0;
    end else begin
      rs_q <= rs_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.channel           = res_q.channel;
  assign out_o.message           = res_q.message;
  assign out_o.pitch             = res_q.pitch;
  assign out_o.velocity          = res_q.velocity;
  assign out_o.pressure          = res_q.pressure;
  assign out_o.controller_number = res_q.controller_number;
  assign out_o.controller_value  = res_q.controller_value;
  assign out_o.instrument        = res_q.instrument;

endmodule

`default_nettype wire

/* rtl/core/mmd_checker.sv */
// Port-level checks for the MIDI message decoder, attached by the bind below.
// Depends on mmd_pkg and midi_message_decoder_unit.
`default_nettype none

module mmd_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [mmd_pkg::ChanW-1:0]    out_channel_i,
  input  wire logic [mmd_pkg::ByteW-1:0]    out_message_i,
  input  wire logic [mmd_pkg::PitchW-1:0]   out_pitch_i,
  input  wire logic [mmd_pkg::ByteW-1:0]    out_velocity_i,
  input  wire logic [mmd_pkg::ByteW-1:0]    out_pressure_i,
  input  wire logic [mmd_pkg::ByteW-1:0]    out_instrument_i
);
  import mmd_pkg::*;

  // A held event keeps its message, channel, pitch and velocity until the receiver takes the beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_message_i)
      && $stable(out_channel_i) && $stable(out_pitch_i) && $stable(out_velocity_i))
    else $error("mmd: held event changed");

  // Every packet beat yields an event in the following cycle.
  a_one_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("mmd: no event after packet beat");

  // An empty output side always takes a packet.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("mmd: packet refused with output empty");

  // A note on with zero velocity only survives when the packet was too short
  // for its parameters, so no note number can come with it.
  a_no_silent_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_message_i == MsgNoteOn && out_velocity_i == '0
      |-> out_pitch_i == '0)
    else $error("mmd: note on with zero velocity");

  // System messages carry channel zero and no parameters.
  a_sys_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_message_i[7:4] == SysNibble |-> out_channel_i == '0
      && out_pitch_i == '0 && out_pressure_i == '0 && out_instrument_i == '0)
    else $error("mmd: system message with parameters");

endmodule

bind midi_message_decoder_unit mmd_checker u_mmd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_channel_i    (out_o.channel),
  .out_message_i    (out_o.message),
  .out_pitch_i      (out_o.pitch),
  .out_velocity_i   (out_o.velocity),
  .out_pressure_i   (out_o.pressure),
  .out_instrument_i (out_o.instrument)
);

`default_nettype wire

/* tb/tb_midi_message_decoder_unit.sv */
// Self-checking testbench for midi_message_decoder_unit: random and directed
// MIDI packets, a running-status predictor and an in-order event scoreboard.
// Depends on mmd_pkg, mmd_in_if, mmd_out_if and the decoder top level.
`timescale 1ns / 1ps

import mmd_pkg::*;

// Holds the running status as the decoder should see it and the decoded
// events still owed by the block, oldest first.
class midi_event_scoreboard;
  logic [ByteW-1:0] running_status;
  mmd_result_t      owed_events[$];
  int unsigned      mismatch_count;
  int unsigned      events_checked;

  function new();
    running_status = '0;
    mismatch_count = 0;
    events_checked = 0;
  endfunction

  function int unsigned pending();
    return owed_events.size();
  endfunction

  function mmd_result_t decode_packet(logic [ByteW-1:0] b0, logic [ByteW-1:0] b1,
                                      logic [ByteW-1:0] b2, logic [LenW-1:0] len);
    mmd_result_t      ev;
    logic [ByteW-1:0] pkt_bytes [3];
    int unsigned      first_param;
    logic [ByteW-1:0] p0;
    logic [ByteW-1:0] p1;
    logic             two_params_ok;
    logic             one_param_ok;
    ev = '0;
    pkt_bytes[0] = b0;
    pkt_bytes[1] = b1;
    pkt_bytes[2] = b2;
    first_param = 1;
    if (len != 0) begin
      if (b0[7:4] == SysNibble) begin
        ev.message = b0;
        running_status = b0;
      end else if (!b0[7]) begin
        // A data byte reuses the stored status; its parameters start at byte 0.
        ev.channel = running_status[3:0];
        ev.message = {4'h0, running_status[7:4]};
        first_param = 0;
      end else begin
        ev.channel = b0[3:0];
        ev.message = {4'h0, b0[7:4]};
        running_status = b0;
      end
    end
    p0 = pkt_bytes[first_param];
    p1 = pkt_bytes[first_param + 1];
    two_params_ok = (int'(len) >= 2 + first_param);
    one_param_ok  = (int'(len) >= 1 + first_param);
    case (ev.message)
      MsgPolyAftertouch: begin
        if (two_params_ok) begin
          ev.pitch    = PitchW'(p0);
          ev.pressure = p1;
        end
      end
      MsgControlChange: begin
        if (two_params_ok) begin
          ev.controller_number = p0;
          ev.controller_value  = p1;
        end
      end
      MsgNoteOn, MsgNoteOff: begin
        if (two_params_ok) begin
          ev.pitch    = PitchW'(p0);
          ev.velocity = p1;
          if (ev.message == MsgNoteOn && p1 == '0) ev.message = MsgNoteOff;
        end
      end
      MsgPitchBend: begin
        if (two_params_ok) ev.pitch = (PitchW'(p1) << 7) | PitchW'(p0);
      end
      MsgProgramChange: begin
        if (one_param_ok) ev.instrument = p0;
      end
      MsgChannelPressure: begin
        if (one_param_ok) ev.pressure = p0;
      end
      default: ;
    endcase
    return ev;
  endfunction

  function void note_packet(logic [ByteW-1:0] b0, logic [ByteW-1:0] b1,
                            logic [ByteW-1:0] b2, logic [LenW-1:0] len);
    owed_events.push_back(decode_packet(b0, b1, b2, len));
  endfunction

  task report_mismatch(string what, int unsigned got_val, int unsigned want_val);
    $display("%0t: event %0d: %s: got 0x%0h, expected 0x%0h",
             $realtime, events_checked, what, got_val, want_val);
    mismatch_count++;
  endtask

  task check_event(mmd_result_t got);
    mmd_result_t want;
    if (owed_events.size() == 0) begin
      report_mismatch("event with no packet outstanding", got.message, 0);
    end else begin
      want = owed_events.pop_front();
      if (got.channel != want.channel)
        report_mismatch("channel", got.channel, want.channel);
      if (got.message != want.message)
        report_mismatch("message", got.message, want.message);
      if (got.pitch != want.pitch)
        report_mismatch("pitch", got.pitch, want.pitch);
      if (got.velocity != want.velocity)
        report_mismatch("velocity", got.velocity, want.velocity);
      if (got.pressure != want.pressure)
        report_mismatch("pressure", got.pressure, want.pressure);
      if (got.controller_number != want.controller_number)
        report_mismatch("controller_number", got.controller_number,
                        want.controller_number);
      if (got.controller_value != want.controller_value)
        report_mismatch("controller_value", got.controller_value,
                        want.controller_value);
      if (got.instrument != want.instrument)
        report_mismatch("instrument", got.instrument, want.instrument);
    end
    events_checked++;
  endtask
endclass

module tb_midi_message_decoder_unit;

  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned PacketsPerPass = 500;
  localparam int unsigned DrainCycles    = 4;

  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [LenW-1:0]  len;
  } midi_packet_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_requests;
  int unsigned quiet_cycles;

  midi_event_scoreboard board = new();

  mmd_in_if  pkt_bus ();
  mmd_out_if evt_bus ();

  midi_message_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pkt_bus),
    .out_o  (evt_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Beat monitor and watchdog; both sample the values from before the edge.
  always @(posedge clk_i) begin
    mmd_result_t got;
    logic        any_beat;
    any_beat = 1'b0;
    if (pkt_bus.valid && pkt_bus.ready) begin
      board.note_packet(pkt_bus.first_byte, pkt_bus.second_byte, pkt_bus.third_byte,
                        pkt_bus.packet_length);
      any_beat = 1'b1;
    end
    if (evt_bus.valid && evt_bus.ready) begin
      got.channel           = evt_bus.channel;
      got.message           = evt_bus.message;
      got.pitch             = evt_bus.pitch;
      got.velocity          = evt_bus.velocity;
      got.pressure          = evt_bus.pressure;
      got.controller_number = evt_bus.controller_number;
      got.controller_value  = evt_bus.controller_value;
      got.instrument        = evt_bus.instrument;
      board.check_event(got);
      any_beat = 1'b1;
    end
    if (any_beat) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Event receiver. A hold-off request keeps ready low for a long stretch so
  // that the output register fills and the decoder refuses packets.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left = 0;
    holds_served = 0;
    evt_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        evt_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        evt_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one packet, idling first at the current rate, and returns after
  // the edge at which it was taken.
  task automatic send_packet(midi_packet_t pkt);
    while ($urandom_range(99) < tx_idle_pct) begin
      pkt_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt_bus.valid         <= 1'b1;
    pkt_bus.first_byte    <= pkt.b0;
    pkt_bus.second_byte   <= pkt.b1;
    pkt_bus.third_byte    <= pkt.b2;
    pkt_bus.packet_length <= pkt.len;
    @(posedge clk_i);
    while (!pkt_bus.ready) @(posedge clk_i);
  endtask

  task automatic send_bytes(logic [ByteW-1:0] b0, logic [ByteW-1:0] b1,
                            logic [ByteW-1:0] b2, logic [LenW-1:0] len);
    midi_packet_t pkt;
    pkt.b0  = b0;
    pkt.b1  = b1;
    pkt.b2  = b2;
    pkt.len = len;
    send_packet(pkt);
  endtask

  // Parameter bytes are mostly proper 7-bit data, now and then with bit 7 set.
  function automatic logic [ByteW-1:0] param_byte();
    if ($urandom_range(9) == 0) return ByteW'($urandom_range(255));
    return ByteW'($urandom_range(127));
  endfunction

  function automatic midi_packet_t random_packet();
    midi_packet_t pkt;
    int unsigned  pick;
    logic [3:0]   kind;
    pick   = $urandom_range(99);
    pkt.b1 = param_byte();
    pkt.b2 = param_byte();
    if (pick < 55) begin
      // Channel status with the length its message type calls for, now and then a random length.
      kind   = 4'($urandom_range(14, 8));
      pkt.b0 = {kind, 4'($urandom_range(15))};
      if (kind == MsgProgramChange[3:0] || kind == MsgChannelPressure[3:0])
        pkt.len = 2'd2;
      else
        pkt.len = 2'd3;
      if ($urandom_range(7) == 0) pkt.len = LenW'($urandom_range(3));
    end else if (pick < 85) begin
      // Running-status packet: data bytes only.
      pkt.b0  = ByteW'($urandom_range(127));
      pkt.len = LenW'($urandom_range(3, 1));
    end else if (pick < 93) begin
      pkt.b0  = ByteW'($urandom_range(255, 240));
      pkt.len = LenW'($urandom_range(3));
    end else begin
      pkt.b0  = ByteW'($urandom);
      pkt.b1  = ByteW'($urandom);
      pkt.b2  = ByteW'($urandom);
      pkt.len = LenW'($urandom);
    end
    return pkt;
  endfunction

  task automatic send_random_packets(int unsigned count);
    repeat (count) send_packet(random_packet());
  endtask

  initial begin
    quiet_cycles  = 0;
    hold_requests = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rst_ni                <= 1'b0;
    pkt_bus.valid         <= 1'b0;
    pkt_bus.first_byte    <= '0;
    pkt_bus.second_byte   <= '0;
    pkt_bus.third_byte    <= '0;
    pkt_bus.packet_length <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a data byte straight after reset finds a zero running status.
    send_bytes(8'h3C, 8'h7F, 8'h55, 2'd3);
    send_bytes(8'hFF, 8'hFF, 8'hFF, 2'd0);
    send_bytes(8'h00, 8'h00, 8'h00, 2'd3);
    send_bytes(8'h90, 8'h3C, 8'h64, 2'd3);
    send_bytes(8'h9F, 8'h40, 8'h00, 2'd3);
    send_bytes(8'h85, 8'h7F, 8'h7F, 2'd3);
    send_bytes(8'hA3, 8'h22, 8'h11, 2'd3);
    send_bytes(8'hB7, 8'h07, 8'h7F, 2'd3);
    send_bytes(8'hC2, 8'h7F, 8'hAA, 2'd2);
    send_bytes(8'hDE, 8'hFF, 8'hAA, 2'd2);
    send_bytes(8'hEF, 8'hFF, 8'hFF, 2'd3);
    // Packets too short for their parameters.
    send_bytes(8'h93, 8'h40, 8'h40, 2'd2);
    send_bytes(8'hC5, 8'h10, 8'h00, 2'd1);
    // Running status for a note on, then for a short packet.
    send_bytes(8'h90, 8'h00, 8'h00, 2'd1);
    send_bytes(8'h40, 8'h7F, 8'hFF, 2'd2);
    send_bytes(8'h41, 8'h00, 8'h00, 2'd2);
    send_bytes(8'h42, 8'h33, 8'h33, 2'd1);
    send_bytes(8'hC4, 8'h00, 8'h00, 2'd1);
    send_bytes(8'h05, 8'h00, 8'h00, 2'd1);
    send_bytes(8'hE0, 8'h00, 8'h00, 2'd1);
    send_bytes(8'hFF, 8'hFF, 8'h80, 2'd2);
    // A data byte after a system status splits the stored byte into nibbles.
    send_bytes(8'hF8, 8'h12, 8'h34, 2'd1);
    send_bytes(8'h7F, 8'h7F, 8'h7F, 2'd3);
    send_bytes(8'hFF, 8'h01, 8'h02, 2'd3);

    tx_idle_pct = 19;
    rx_idle_pct = 65;
    send_random_packets(PacketsPerPass);
    tx_idle_pct = 65;
    rx_idle_pct = 19;
    send_random_packets(PacketsPerPass);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    send_random_packets(PacketsPerPass);
    pkt_bus.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
